[rtl/b85dec_pkg.sv]
// Types, result codes and the character lookup for the Z85 text decoder.
// No dependencies; imported by base85_text_decoder.
package b85dec_pkg;

  localparam int unsigned GroupChars = 5;
  localparam int unsigned GroupBytes = 4;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);

  localparam logic [31:0] Radix = 32'd85;

  localparam logic [1:0] STATUS_DATA      = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] digit;
  } symbol_t;

  // Maps one character to its Z85 digit; ok is low outside the alphabet.
  function automatic symbol_t z85_symbol(input logic [7:0] ch);
    symbol_t    s;
    logic [7:0] d;
    s = '{ok: 1'b1, digit: 7'd0};
    d = 8'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'd48;
      s.digit = d[6:0];
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      d = ch - 8'd87;
      s.digit = d[6:0];
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      d = ch - 8'd29;
      s.digit = d[6:0];
    end else begin
      unique case (ch)
        8'h2e: s.digit = 7'd62;  // .
        8'h2d: s.digit = 7'd63;  // -
        8'h3a: s.digit = 7'd64;  // :
        8'h2b: s.digit = 7'd65;  // +
        8'h3d: s.digit = 7'd66;  // =
        8'h5e: s.digit = 7'd67;  // ^
        8'h21: s.digit = 7'd68;  // !
        8'h2f: s.digit = 7'd69;  // /
        8'h2a: s.digit = 7'd70;  // *
        8'h3f: s.digit = 7'd71;  // ?
        8'h26: s.digit = 7'd72;  // &
        8'h3c: s.digit = 7'd73;  // <
        8'h3e: s.digit = 7'd74;  // >
        8'h28: s.digit = 7'd75;  // (
        8'h29: s.digit = 7'd76;  // )
        8'h5b: s.digit = 7'd77;  // [
        8'h5d: s.digit = 7'd78;  // ]
        8'h7b: s.digit = 7'd79;  // {
        8'h7d: s.digit = 7'd80;  // }
        8'h40: s.digit = 7'd81;  // @
        8'h25: s.digit = 7'd82;  // %
        8'h24: s.digit = 7'd83;  // $
        8'h23: s.digit = 7'd84;  // #
        default: s.ok = 1'b0;
      endcase
    end
    return s;
  endfunction

endpackage

[rtl/base85_text_decoder.sv]
// Z85 text decoder: one character word in, decoded byte or error words out.
// Depends on b85dec_pkg for the result type, status codes and lookup.
//
//   channel | direction | word
//   in_     | input     | character, message_last
//   out_    | output    | data_byte, status, run_last
//
// A character word is registered, decoded in the next cycle and its results
// (none, one error word, or four bytes) land in a 16-entry result queue. The queue head
// drives the out_ ports, so a word can leave in the cycle after it is queued.
// One character is taken per cycle while the queue has room for the words of
// the character in flight and the next one; five characters make four bytes.
// Reset (rst_n low, synchronous) empties the queue and clears the group state.
module base85_text_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       in_message_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  output logic       out_run_last
);
  import b85dec_pkg::*;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // Group state.
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        err_r, err_nxt;

  // Result queue.
  result_t           queue_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CountW-1:0] count_r, count_nxt;

  result_t    push_word [GroupBytes];
  logic [2:0] push_cnt;
  logic       pop;

  symbol_t     sym;
  logic [31:0] acc_step;

  assign sym      = z85_symbol(s1_char_r);
  assign acc_step = acc_r * Radix + {25'd0, sym.digit};

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    push_cnt = 3'd0;
    for (int i = 0; i < GroupBytes; i++) begin
      push_word[i] = '{data_byte: 8'd0, status: STATUS_DATA, run_last: 1'b0};
    end
    if (s1_valid_r) begin
      priority if (err_r) begin
        // The rest of a bad message is dropped until its last character.
        if (s1_last_r) begin
          err_nxt = 1'b0;
        end
      end else if (!sym.ok) begin
        push_cnt     = 3'd1;
        push_word[0] = '{data_byte: 8'd0, status: STATUS_BAD_CHAR, run_last: 1'b1};
        acc_nxt      = 32'd0;
        cnt_nxt      = 3'd0;
        err_nxt      = !s1_last_r;
      end else if (cnt_r == 3'(GroupChars - 1)) begin
        push_cnt = 3'(GroupBytes);
        for (int i = 0; i < GroupBytes; i++) begin
          push_word[i].data_byte = acc_step[8*(GroupBytes-1-i) +: 8];
          push_word[i].run_last  = (i == GroupBytes - 1);
        end
        acc_nxt = 32'd0;
        cnt_nxt = 3'd0;
      end else if (s1_last_r) begin
        push_cnt     = 3'd1;
        push_word[0] = '{data_byte: 8'd0, status: STATUS_TRUNCATED, run_last: 1'b1};
        acc_nxt      = 32'd0;
        cnt_nxt      = 3'd0;
      end else begin
        acc_nxt = acc_step;
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  assign out_valid     = (count_r != '0);
  assign pop           = out_valid && out_ready;
  assign out_data_byte = queue_r[rd_ptr_r].data_byte;
  assign out_status    = queue_r[rd_ptr_r].status;
  assign out_run_last  = queue_r[rd_ptr_r].run_last;

  // The item in the input register always drains, so there must be room for
  // its words and for those of the item taken now.
  assign in_ready = ((s1_valid_r ? count_r + CountW'(GroupBytes) : count_r)
                     <= CountW'(QueueDepth - GroupBytes));

  assign count_nxt = count_r + CountW'(push_cnt) - CountW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      acc_r      <= 32'd0;
      cnt_r      <= 3'd0;
      err_r      <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      s1_valid_r <= in_valid && in_ready;
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
      err_r      <= err_nxt;
      wr_ptr_r   <= wr_ptr_r + PtrW'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_character;
      s1_last_r <= in_message_last;
    end
    for (int i = 0; i < GroupBytes; i++) begin
      if (3'(i) < push_cnt) begin
        queue_r[wr_ptr_r + PtrW'(i)] <= push_word[i];
      end
    end
  end

endmodule

[sim/base85_text_decoder_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for base85_text_decoder: Z85 character words in, byte or error words out.
// Depends on b85dec_pkg for the result type and status codes and on the decoder RTL.
module base85_text_decoder_test;
  import b85dec_pkg::*;

  localparam string Z85Alphabet =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 20;
  localparam int RandomChars = 350;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } char_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_character = 8'd0;
  logic       in_message_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic [1:0] out_status;
  logic       out_run_last;

  base85_text_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_character    (in_character),
    .in_message_last (in_message_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_status      (out_status),
    .out_run_last    (out_run_last)
  );

  char_word_t char_q[$];
  result_t    decoded_q[$];
  int         digit_lut[256];

  // Decoder state mirrored by the predictor.
  logic [31:0] group_acc = 32'd0;
  int          group_cnt = 0;
  bit          skip_msg = 1'b0;

  bit         in_took = 1'b0;
  int         sent_cnt = 0;
  int         cycle_cnt = 0;
  int         errors = 0;
  char_word_t next_word;
  result_t    want;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void push_status(input logic [1:0] st);
    result_t r;
    r.data_byte = 8'd0;
    r.status    = st;
    r.run_last  = 1'b1;
    decoded_q.push_back(r);
  endfunction

  function automatic void z85_decode_char(input logic [7:0] ch, input logic fin);
    int      d;
    result_t r;
    if (skip_msg) begin
      if (fin) skip_msg = 1'b0;
      return;
    end
    d = digit_lut[ch];
    if (d < 0) begin
      push_status(STATUS_BAD_CHAR);
      group_acc = 32'd0;
      group_cnt = 0;
      skip_msg  = !fin;
      return;
    end
    group_acc = group_acc * 32'd85 + 32'(d);
    group_cnt++;
    if (group_cnt == GroupChars) begin
      for (int k = 0; k < GroupBytes; k++) begin
        r.data_byte = group_acc[31 - 8 * k -: 8];
        r.status    = STATUS_DATA;
        r.run_last  = (k == GroupBytes - 1);
        decoded_q.push_back(r);
      end
      group_acc = 32'd0;
      group_cnt = 0;
    end else if (fin) begin
      push_status(STATUS_TRUNCATED);
      group_acc = 32'd0;
      group_cnt = 0;
    end
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic fin);
    char_word_t w;
    w.ch  = ch;
    w.fin = fin;
    char_q.push_back(w);
  endfunction

  function automatic void push_text(input string s, input bit fin_on_end);
    for (int i = 0; i < s.len(); i++) push_char(s[i], fin_on_end && (i == s.len() - 1));
  endfunction

  function automatic logic [7:0] random_bad_char();
    logic [7:0] ch;
    ch = 8'($urandom_range(255));
    while (digit_lut[ch] >= 0) ch = 8'($urandom_range(255));
    return ch;
  endfunction

  // A long quiet stretch in the middle of the run: neither side idles there.
  function automatic int idle_pct();
    return (sent_cnt >= 140 && sent_cnt < 220) ? 0 : 18;
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (char_q.size() != 0 && $urandom_range(99) >= idle_pct()) begin
          next_word = char_q.pop_front();
          in_character    <= next_word.ch;
          in_message_last <= next_word.fin;
          in_valid        <= 1'b1;
          sent_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct());
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word data_byte=%02h status=%0d run_last=%0b",
                 $realtime, out_data_byte, out_status, out_run_last);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_data_byte !== want.data_byte) begin
          $display("%0t: data_byte expected %02h actual %02h",
                   $realtime, want.data_byte, out_data_byte);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, out_status);
          errors++;
        end
        if (out_run_last !== want.run_last) begin
          $display("%0t: run_last expected %0b actual %0b",
                   $realtime, want.run_last, out_run_last);
          errors++;
        end
      end
    end
    in_took = rst_n && in_valid && in_ready;
    if (in_took) z85_decode_char(in_character, in_message_last);
  end

  initial begin
    int kind;
    int len;
    int bad_at;
    logic [7:0] ch;

    for (int i = 0; i < 256; i++) digit_lut[i] = -1;
    for (int i = 0; i < Z85Alphabet.len(); i++) digit_lut[Z85Alphabet[i]] = i;

    // Directed: a group closed by the last character, the largest group (wraps past 2^32)
    // followed by a truncated tail, an error mid-message with ignored words after it,
    // invalid characters that also end the message, and a one-character truncation.
    push_text("00000", 1'b1);
    push_text("#####%", 1'b1);
    push_text("9a", 1'b0);
    push_char(8'h00, 1'b0);
    push_text("ZZ", 1'b0);
    push_char(8'hFF, 1'b1);
    push_char(8'hFF, 1'b1);
    push_text(".", 1'b1);
    push_text("rst^!", 1'b0);
    push_char(8'h00, 1'b1);

    while (char_q.size() < 24 + RandomChars) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) push_char(8'($urandom_range(255)), i == len - 1);
      end else begin
        len = 5 * $urandom_range(1, 4);
        if (kind < 27) len = len - $urandom_range(1, 4);
        bad_at = (kind >= 27 && kind < 37) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          ch = (i == bad_at) ? random_bad_char() : Z85Alphabet[$urandom_range(84)];
          push_char(ch, i == len - 1);
        end
      end
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while ((char_q.size() != 0 || in_valid || decoded_q.size() != 0) && cycle_cnt < CycleLimit)
      @(negedge clk);
    if (cycle_cnt >= CycleLimit) begin
      $display("base85_text_decoder_test failed");
    end else begin
      repeat (DrainCycles) @(negedge clk);
      if (errors == 0 && decoded_q.size() == 0) begin
        $display("base85_text_decoder_test passed");
      end else begin
        if (decoded_q.size() != 0)
          $display("%0t: %0d expected words never arrived", $realtime, decoded_q.size());
        $display("base85_text_decoder_test failed");
      end
    end
    $finish;
  end

endmodule

[base85_text_decoder.f]
rtl/b85dec_pkg.sv
rtl/base85_text_decoder.sv
sim/base85_text_decoder_test.sv
